/* rtl/core/rzw_pkg.sv */
// Shared types, constants and helper functions of the rotate/zoom texture coordinate warp.
`timescale 1ns / 1ps
`default_nettype none

package rzw_pkg;

    localparam int unsigned FRAC_BITS  = 14;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R0_C0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R0_C1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R1_C0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R1_C1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R2_C0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_R2_C1 = 3'd5;

    localparam logic signed [FIELD_W-1:0] ROT_ONE  = FIELD_W'(1 << FRAC_BITS);
    localparam logic signed [FIELD_W-1:0] ROT_ZERO = '0;

    localparam int unsigned PROD_W   = 2 * FIELD_W;
    localparam int unsigned SUM_W    = PROD_W + 1;
    localparam int unsigned RSQ_W    = PROD_W;
    localparam int unsigned LEN_W    = FIELD_W;
    localparam int unsigned SQ_STAGES = RSQ_W / 4;

    localparam int unsigned ZOOM_DIV  = 20;
    localparam int unsigned ZOOM_BIAS = 19 * (1 << FRAC_BITS) + ZOOM_DIV / 2;
    localparam int unsigned NUM_W     = 19;
    localparam int unsigned RECIP_SH  = 24;
    localparam int unsigned RECIP_W   = 20;
    localparam logic [RECIP_W-1:0] ZOOM_RECIP =
        RECIP_W'(((1 << RECIP_SH) + ZOOM_DIV - 1) / ZOOM_DIV);
    localparam int unsigned QPROD_W   = NUM_W + RECIP_W;
    localparam int unsigned SCALE_W   = QPROD_W - RECIP_SH;

    localparam int unsigned BPROD_W   = SUM_W + SCALE_W + 1;
    localparam int unsigned BC_W      = BPROD_W - FRAC_BITS;
    localparam int unsigned XP_W      = BC_W + FIELD_W;
    localparam int unsigned ACC_W     = XP_W + 2;
    localparam int unsigned TEX_SH    = 2 * FRAC_BITS + 1;
    localparam int unsigned TEX_W     = ACC_W - TEX_SH + 1;

    localparam logic signed [BPROD_W-1:0] PROJ_HALF = BPROD_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]   TEX_HALF  = ACC_W'(64'd1 << (TEX_SH - 1));
    localparam logic signed [TEX_W-1:0]   TEX_OFS   = TEX_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [TEX_W-1:0]   TEX_MAX   = TEX_W'(32767);
    localparam logic signed [TEX_W-1:0]   TEX_MIN   = -TEX_W'(32768);

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_u;
        logic signed [FIELD_W-1:0] point_v;
    } t_point;

    typedef struct packed {
        logic signed [FIELD_W-1:0] tex_x;
        logic signed [FIELD_W-1:0] tex_y;
    } t_tex;

    typedef struct packed {
        logic [RSQ_W-1:0] rem;
        logic [RSQ_W-1:0] root;
    } t_sqrt_state;

    function automatic t_sqrt_state sqrt_iter(input t_sqrt_state st, input int unsigned step);
        logic [RSQ_W-1:0] bitv;
        logic [RSQ_W-1:0] trial;
        t_sqrt_state      nx;
        bitv  = RSQ_W'(1) << (RSQ_W - 2 - 2 * step);
        trial = st.root + bitv;
        if (st.rem >= trial) begin
            nx.rem  = st.rem - trial;
            nx.root = (st.root >> 1) + bitv;
        end else begin
            nx.rem  = st.rem;
            nx.root = st.root >> 1;
        end
        return nx;
    endfunction

    function automatic logic signed [FIELD_W-1:0] tex_of(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [TEX_W-1:0] val;
        rnd = acc + TEX_HALF;
        val = TEX_W'($signed(rnd[ACC_W-1:TEX_SH])) + TEX_OFS;
        if (val > TEX_MAX) begin
            return TEX_MAX[FIELD_W-1:0];
        end else if (val < TEX_MIN) begin
            return TEX_MIN[FIELD_W-1:0];
        end
        return val[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rzw_sqrt.sv */
// Pipelined integer square root, two restoring steps per stage, root and remainder out.
`timescale 1ns / 1ps
`default_nettype none

module rzw_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rzw_pkg::RSQ_W-1:0]     i_radsq,
    output logic                          o_valid,
    output logic [rzw_pkg::LEN_W-1:0]     o_root,
    output logic [rzw_pkg::LEN_W:0]       o_rem
);
    import rzw_pkg::*;

    localparam int unsigned LAST = SQ_STAGES - 1;

    t_sqrt_state            r_st [SQ_STAGES];
    t_sqrt_state            w_in [SQ_STAGES];
    t_sqrt_state            w_out[SQ_STAGES];
    logic [SQ_STAGES-1:0]   r_vld;

    genvar s;
    for (s = 0; s < SQ_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_in[s] = '{rem: i_radsq, root: '0};
        end else begin : g_next
            assign w_in[s] = r_st[s-1];
        end
        assign w_out[s] = sqrt_iter(sqrt_iter(w_in[s], 2 * s), 2 * s + 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= w_out[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_root  = r_st[LAST].root[LEN_W-1:0];
    assign o_rem   = r_st[LAST].rem[LEN_W:0];

`ifndef SYNTHESIS
    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_st[LAST].root[RSQ_W-1:LEN_W] == '0)
        else $error("square root exceeds its width");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, r_st[LAST].rem} <= {r_st[LAST].root, 1'b0})
        else $error("square root remainder above twice the root");

    a_rem_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_st[LAST].rem[RSQ_W-1:LEN_W+1] == '0)
        else $error("square root remainder exceeds its width");
`endif

endmodule

`default_nettype wire

/* rtl/core/rotate_zoom_texcoord_warp.sv */
// Top level of the rotate/zoom texture coordinate warp pipeline.
//
// Input channel: i_valid / o_stall carry one screen point (point_u, point_v,
// signed Q1.14) per transfer. Output channel: o_valid / i_stall carry one
// texture coordinate (tex_x, tex_y, signed Q1.14, saturated) per point, in order.
// Configuration: i_cfg_valid / o_cfg_ready write the six rotation entries by
// index 0..5; indexes 6 and 7 are ignored. o_cfg_ready is always high. Write
// only while no point is in flight.
// Throughput: one point per clock while o_stall is low. A point passes through
// two multiply/add stages, eight square root stages, six stages of zoom scaling
// and back rotation, and the output register before it shows on o_valid.
// When the receiver stalls, the result holds in the output register and one
// more result goes into a skid register; o_stall rises only while the skid
// register is full, and the whole pipeline then holds without loss.
// Reset clears all valid bits and loads the identity rotation (first two
// rows of the unit matrix, third row zero).
`timescale 1ns / 1ps
`default_nettype none

module rotate_zoom_texcoord_warp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  rzw_pkg::t_point                    i_point,
    output logic                               o_valid,
    input  logic                               i_stall,
    output rzw_pkg::t_tex                      o_tex,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rzw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rzw_pkg::FIELD_W-1:0]        i_cfg_data
);
    import rzw_pkg::*;

    logic signed [FIELD_W-1:0] r_rot00, r_rot01, r_rot10, r_rot11, r_rot20, r_rot21;

    logic                      en;
    logic                      r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;

    logic signed [PROD_W-1:0]  r1_uu, r1_vv, r1_m00, r1_m01, r1_m10, r1_m11, r1_m20, r1_m21;
    logic [RSQ_W-1:0]          r2_radsq;
    logic signed [SUM_W-1:0]   r2_a, r2_p1, r2_p2;

    logic signed [SUM_W-1:0]   r_dly_a [SQ_STAGES];
    logic signed [SUM_W-1:0]   r_dly_p1[SQ_STAGES];
    logic signed [SUM_W-1:0]   r_dly_p2[SQ_STAGES];

    logic                      sq_vld;
    logic [LEN_W-1:0]          sq_root;
    logic [LEN_W:0]            sq_rem;

    logic [NUM_W-1:0]          r3_num;
    logic signed [SUM_W-1:0]   r3_a, r3_p1, r3_p2;
    logic [QPROD_W-1:0]        r4_prod;
    logic signed [SUM_W-1:0]   r4_a, r4_p1, r4_p2;
    logic [SCALE_W-1:0]        w_scale;
    logic signed [BPROD_W-1:0] r5_pb, r5_pc;
    logic signed [SUM_W-1:0]   r5_a;
    logic signed [BPROD_W-1:0] w_pb_rnd, w_pc_rnd;
    logic signed [BC_W-1:0]    r6_b, r6_c;
    logic signed [SUM_W-1:0]   r6_a;
    logic signed [XP_W-1:0]    r7_xa, r7_xb, r7_xc, r7_ya, r7_yb, r7_yc;
    logic signed [ACC_W-1:0]   r8_x, r8_y;

    t_tex                      w_res;
    logic                      r_out_vld, r_skid_vld;
    t_tex                      r_out, r_skid;
    logic                      take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot00 <= ROT_ONE;
            r_rot01 <= ROT_ZERO;
            r_rot10 <= ROT_ZERO;
            r_rot11 <= ROT_ONE;
            r_rot20 <= ROT_ZERO;
            r_rot21 <= ROT_ZERO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROT_R0_C0: r_rot00 <= i_cfg_data;
                CFG_ROT_R0_C1: r_rot01 <= i_cfg_data;
                CFG_ROT_R1_C0: r_rot10 <= i_cfg_data;
                CFG_ROT_R1_C1: r_rot11 <= i_cfg_data;
                CFG_ROT_R2_C0: r_rot20 <= i_cfg_data;
                CFG_ROT_R2_C1: r_rot21 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= sq_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_uu  <= PROD_W'(i_point.point_u) * PROD_W'(i_point.point_u);
            r1_vv  <= PROD_W'(i_point.point_v) * PROD_W'(i_point.point_v);
            r1_m00 <= PROD_W'(i_point.point_u) * PROD_W'(r_rot00);
            r1_m01 <= PROD_W'(i_point.point_v) * PROD_W'(r_rot01);
            r1_m10 <= PROD_W'(i_point.point_u) * PROD_W'(r_rot10);
            r1_m11 <= PROD_W'(i_point.point_v) * PROD_W'(r_rot11);
            r1_m20 <= PROD_W'(i_point.point_u) * PROD_W'(r_rot20);
            r1_m21 <= PROD_W'(i_point.point_v) * PROD_W'(r_rot21);

            r2_radsq <= $unsigned(r1_uu) + $unsigned(r1_vv);
            r2_a     <= SUM_W'(r1_m00) + SUM_W'(r1_m01);
            r2_p1    <= SUM_W'(r1_m10) + SUM_W'(r1_m11);
            r2_p2    <= SUM_W'(r1_m20) + SUM_W'(r1_m21);

            r_dly_a[0]  <= r2_a;
            r_dly_p1[0] <= r2_p1;
            r_dly_p2[0] <= r2_p2;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_dly_a[k]  <= r_dly_a[k-1];
                r_dly_p1[k] <= r_dly_p1[k-1];
                r_dly_p2[k] <= r_dly_p2[k-1];
            end
        end
    end

    rzw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_radsq (r2_radsq),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_rem   (sq_rem)
    );

    assign w_scale  = r4_prod[RECIP_SH +: SCALE_W];
    assign w_pb_rnd = r5_pb + PROJ_HALF;
    assign w_pc_rnd = r5_pc + PROJ_HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num <= NUM_W'(ZOOM_BIAS) + NUM_W'(sq_root)
                      + NUM_W'(sq_rem > {1'b0, sq_root});
            r3_a   <= r_dly_a[SQ_STAGES-1];
            r3_p1  <= r_dly_p1[SQ_STAGES-1];
            r3_p2  <= r_dly_p2[SQ_STAGES-1];

            r4_prod <= QPROD_W'(r3_num) * QPROD_W'(ZOOM_RECIP);
            r4_a    <= r3_a;
            r4_p1   <= r3_p1;
            r4_p2   <= r3_p2;

            r5_pb <= BPROD_W'(r4_p1) * BPROD_W'($signed({1'b0, w_scale}));
            r5_pc <= BPROD_W'(r4_p2) * BPROD_W'($signed({1'b0, w_scale}));
            r5_a  <= r4_a;

            r6_b <= w_pb_rnd[BPROD_W-1:FRAC_BITS];
            r6_c <= w_pc_rnd[BPROD_W-1:FRAC_BITS];
            r6_a <= r5_a;

            r7_xa <= XP_W'(r6_a) * XP_W'(r_rot00);
            r7_xb <= XP_W'(r6_b) * XP_W'(r_rot10);
            r7_xc <= XP_W'(r6_c) * XP_W'(r_rot20);
            r7_ya <= XP_W'(r6_a) * XP_W'(r_rot01);
            r7_yb <= XP_W'(r6_b) * XP_W'(r_rot11);
            r7_yc <= XP_W'(r6_c) * XP_W'(r_rot21);

            r8_x <= ACC_W'(r7_xa) + ACC_W'(r7_xb) + ACC_W'(r7_xc);
            r8_y <= ACC_W'(r7_ya) + ACC_W'(r7_yb) + ACC_W'(r7_yc);
        end
    end

    assign w_res.tex_x = tex_of(r8_x);
    assign w_res.tex_y = tex_of(r8_y);

    assign take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r8_vld) begin
            if (r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (r8_vld) begin
            if (r_out_vld && !take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_tex   = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full with output register empty");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && i_stall |=> r_skid_vld && r_out_vld)
        else $error("result dropped while output stalled");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r8_vld && r_out_vld && i_stall |=> r_skid_vld)
        else $error("result not caught by skid register");
`endif

endmodule

`default_nettype wire

/* tb/tb_rotate_zoom_texcoord_warp.sv */
// Self-checking testbench for the rotate/zoom texture coordinate warp.
`timescale 1ns / 1ps

module tb_rotate_zoom_texcoord_warp;
    import rzw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam int DRAIN_CYCLES = 24;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_point               i_point     = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_tex                 o_tex;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data  = '0;

    logic signed [FIELD_W-1:0] rot_r0_c0 = ROT_ONE;
    logic signed [FIELD_W-1:0] rot_r0_c1 = ROT_ZERO;
    logic signed [FIELD_W-1:0] rot_r1_c0 = ROT_ZERO;
    logic signed [FIELD_W-1:0] rot_r1_c1 = ROT_ONE;
    logic signed [FIELD_W-1:0] rot_r2_c0 = ROT_ZERO;
    logic signed [FIELD_W-1:0] rot_r2_c1 = ROT_ZERO;

    t_point pending_points[$];
    t_tex   expected_tex[$];
    t_tex   tex_want;
    bit     point_taken = 1'b0;
    int     send_gap_pct = 0;
    int     recv_hold_pct = 0;
    int     send_gap_left = 0;
    int     recv_hold_left = 0;
    int     err_cnt = 0;

    rotate_zoom_texcoord_warp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point     (i_point),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tex       (o_tex),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned nearest_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned cand;
        r = 0;
        for (int i = 17; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (cand * cand <= x) r = cand;
        end
        if (x - r * r > r) r++;
        return r;
    endfunction

    function automatic longint round_shift(input longint val, input int sh);
        return (val + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [FIELD_W-1:0] clamp16(input longint val);
        if (val > 32767) return 16'sh7fff;
        if (val < -32768) return 16'sh8000;
        return val[FIELD_W-1:0];
    endfunction

    function automatic t_tex warp_point(input t_point p);
        longint u, v, len, zoom, a, b, c, x, y;
        longint unsigned r2;
        t_tex t;
        u    = p.point_u;
        v    = p.point_v;
        r2   = longint'(u * u + v * v);
        len  = longint'(nearest_root(r2));
        zoom = (19 * UNIT + len + 10) / 20;
        a    = u * rot_r0_c0 + v * rot_r0_c1;
        b    = round_shift((u * rot_r1_c0 + v * rot_r1_c1) * zoom, FRAC_BITS);
        c    = round_shift((u * rot_r2_c0 + v * rot_r2_c1) * zoom, FRAC_BITS);
        x    = a * rot_r0_c0 + b * rot_r1_c0 + c * rot_r2_c0;
        y    = a * rot_r0_c1 + b * rot_r1_c1 + c * rot_r2_c1;
        t.tex_x = clamp16(round_shift(x, 2 * FRAC_BITS + 1) + UNIT / 2);
        t.tex_y = clamp16(round_shift(y, 2 * FRAC_BITS + 1) + UNIT / 2);
        return t;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        int span;
        span = int'($urandom_range(0, 32768)) - 16384;
        if ($urandom_range(0, 5) == 0) return FIELD_W'($urandom);
        return span[FIELD_W-1:0];
    endfunction

    // point driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || point_taken) begin
            if (send_gap_left > 0) begin
                send_gap_left--;
                i_valid <= 1'b0;
            end else if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
                send_gap_left = $urandom_range(0, 5);
                i_valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
                i_point <= pending_points.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left--;
            i_stall <= 1'b1;
        end else if (recv_hold_pct != 0 && $urandom_range(0, 99) < recv_hold_pct) begin
            recv_hold_left = $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        point_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_tex.push_back(warp_point(i_point));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tex.size() == 0) begin
                $error("unexpected result: tex_x %0d tex_y %0d", o_tex.tex_x, o_tex.tex_y);
                err_cnt++;
            end else begin
                tex_want = expected_tex.pop_front();
                if (o_tex.tex_x !== tex_want.tex_x) begin
                    $error("tex_x: expected %0d, actual %0d", tex_want.tex_x, o_tex.tex_x);
                    err_cnt++;
                end
                if (o_tex.tex_y !== tex_want.tex_y) begin
                    $error("tex_y: expected %0d, actual %0d", tex_want.tex_y, o_tex.tex_y);
                    err_cnt++;
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ROT_R0_C0: rot_r0_c0 = val;
            CFG_ROT_R0_C1: rot_r0_c1 = val;
            CFG_ROT_R1_C0: rot_r1_c0 = val;
            CFG_ROT_R1_C1: rot_r1_c1 = val;
            CFG_ROT_R2_C0: rot_r2_c0 = val;
            CFG_ROT_R2_C1: rot_r2_c1 = val;
            default: ;
        endcase
    endtask

    task automatic load_rotation(input logic [FIELD_W-1:0] r00, r01, r10, r11, r20, r21);
        cfg_write(CFG_SPARE_6, rand_field());
        cfg_write(CFG_ROT_R0_C0, r00);
        cfg_write(CFG_ROT_R0_C1, r01);
        cfg_write(CFG_ROT_R1_C0, r10);
        cfg_write(CFG_ROT_R1_C1, r11);
        cfg_write(CFG_ROT_R2_C0, r20);
        cfg_write(CFG_ROT_R2_C1, r21);
        cfg_write(CFG_SPARE_7, rand_field());
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_point(input int u, input int v);
        t_point p;
        p.point_u = u[FIELD_W-1:0];
        p.point_v = v[FIELD_W-1:0];
        pending_points.push_back(p);
    endtask

    task automatic push_directed();
        push_point(0, 0);
        push_point(16384, 0);
        push_point(0, 16384);
        push_point(-16384, 0);
        push_point(0, -16384);
        push_point(16384, 16384);
        push_point(-16384, -16384);
        push_point(16384, -16384);
        push_point(-16384, 16384);
        push_point(1, -1);
        push_point(-1, -1);
        push_point(32767, 32767);
        push_point(-32768, -32768);
        push_point(-32768, 32767);
        push_point(11585, -11585);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++) begin
            push_point(int'($signed(rand_field())), int'($signed(rand_field())));
        end
    endtask

    task automatic pick_pacing();
        int sel;
        sel = $urandom_range(0, 2);
        send_gap_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
        sel = $urandom_range(0, 2);
        recv_hold_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_points.size() != 0 || i_valid || expected_tex.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        load_rotation(rand_field(), rand_field(), rand_field(),
                      rand_field(), rand_field(), rand_field());
        pick_pacing();
        push_random(count);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pick_pacing();
        push_directed();
        push_random(80);
        drain();

        load_rotation(16'sd16384, 16'sd16384, 16'sd16384,
                      16'sd16384, 16'sd16384, 16'sd16384);
        pick_pacing();
        push_random(60);
        drain();

        load_rotation(-16'sd16384, -16'sd16384, -16'sd16384,
                      -16'sd16384, -16'sd16384, -16'sd16384);
        pick_pacing();
        push_random(60);
        drain();

        load_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        pick_pacing();
        push_directed();
        push_random(50);
        drain();

        load_rotation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        pick_pacing();
        push_random(50);
        drain();

        load_rotation(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, -16'sd16384);
        pick_pacing();
        push_random(60);
        drain();

        repeat (3) random_phase(60);

        send_gap_pct  = 0;
        recv_hold_pct = 0;
        load_rotation(rand_field(), rand_field(), rand_field(),
                      rand_field(), rand_field(), rand_field());
        push_random(80);
        drain();

        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_500_000;
        $display("status: fail");
        $finish;
    end

endmodule
